// ===== hw/rtl/knntb_pkg.sv =====
// Shared types and constants of the exact k-nearest-neighbor block.
`default_nettype none
package knntb_pkg;

	localparam logic [38:0] DIST_SAT  = 39'h7F_FFFF_FFFF;
	localparam logic [9:0]  COUNT_SAT = 10'd1023;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_NBR   = 2'd1;
	localparam logic [1:0] STATUS_BAD_QUERY = 2'd2;

	localparam logic [7:0] REG_POOL_COUNT = 8'd0;
	localparam logic [7:0] REG_DIM_IN_USE = 8'd1;
	localparam logic [7:0] REG_TRUTH_K    = 8'd2;
	localparam logic [7:0] REG_RECALL_K   = 8'd3;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [9:0]         vector_index;
		logic [6:0]         component_index;
		logic signed [15:0] component_value;
		logic [9:0]         query_index;
	} req_t;

	typedef struct packed {
		logic [4:0]  neighbor_rank;
		logic [9:0]  neighbor_id;
		logic [38:0] distance;
		logic [9:0]  band_count;
		logic [9:0]  band_wide_count;
		logic [1:0]  status;
		logic        last;
	} rsp_t;

	typedef enum logic [1:0] {
		CMD_LOAD,
		CMD_DROP,
		CMD_QUERY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [9:0]         vector_index;
		logic [6:0]         component_index;
		logic signed [15:0] component_value;
		logic [9:0]         query_index;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_NEXT,
		ST_RUN,
		ST_DRAIN,
		ST_UPDATE,
		ST_LATCH_W,
		ST_LATCH_B,
		ST_EMIT,
		ST_EMIT_ERR
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/knntb_front.sv =====
// Front end: accepts request beats, classifies them and queues commands.
`default_nettype none
module knntb_front #(
	parameter int POOL_MAX = 1024,
	parameter int DIM_MAX  = 128
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  knntb_pkg::req_t    req,
	output logic               cmd_valid,
	input  wire                cmd_pop,
	output knntb_pkg::cmd_t    cmd
);
	import knntb_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       cls_w;
	logic       push_w;
	logic       pop_w;

	always_comb begin
		cls_w.vector_index    = req.vector_index;
		cls_w.component_index = req.component_index;
		cls_w.component_value = req.component_value;
		cls_w.query_index     = req.query_index;
		if (req.req_type == REQ_QUERY) begin
			cls_w.kind = CMD_QUERY;
		end else if (32'(req.vector_index) < POOL_MAX &&
			32'(req.component_index) < DIM_MAX) begin
			cls_w.kind = CMD_LOAD;
		end else begin
			cls_w.kind = CMD_DROP;
		end
	end

	assign req_ready = (fill_q != 2'd2);
	assign push_w    = req_valid && req_ready;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop_w     = cmd_pop && cmd_valid;
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_w) begin
			entry_q[wr_ptr_q] <= cls_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push_w) wr_ptr_q <= ~wr_ptr_q;
			if (pop_w)  rd_ptr_q <= ~rd_ptr_q;
			if (push_w && !pop_w) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop_w && !push_w) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/knntb_back.sv =====
// Back end: vector store, distance pipeline, sorted best list and result output.
`default_nettype none
module knntb_back #(
	parameter int POOL_MAX = 1024,
	parameter int DIM_MAX  = 128,
	parameter int K_MAX    = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cmd_valid,
	output logic              cmd_pop,
	input  knntb_pkg::cmd_t   cmd,
	input  wire               cfg_we,
	input  wire [7:0]         cfg_index,
	input  wire [10:0]        cfg_data,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output knntb_pkg::rsp_t   rsp
);
	import knntb_pkg::*;

	localparam int DEPTH = POOL_MAX * DIM_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IX_W  = $clog2(POOL_MAX);
	localparam int PC_W  = $clog2(POOL_MAX + 1);
	localparam int DIM_W = $clog2(DIM_MAX + 1);
	localparam int KC_W  = $clog2(K_MAX + 1);
	localparam int KI_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;

	// Configuration registers.
	logic [10:0] pool_count_q;
	logic [7:0]  dim_in_use_q;
	logic [5:0]  truth_k_q;
	logic [5:0]  recall_k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_count_q <= 11'd0;
			dim_in_use_q <= 8'd128;
			truth_k_q    <= 6'd10;
			recall_k_q   <= 6'd30;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POOL_COUNT: pool_count_q <= cfg_data;
				REG_DIM_IN_USE: dim_in_use_q <= cfg_data[7:0];
				REG_TRUTH_K:    truth_k_q    <= cfg_data[5:0];
				REG_RECALL_K:   recall_k_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;

	logic [9:0]      qi_q;
	logic [PC_W-1:0] npool_q;
	logic [DIM_W-1:0] dim_q;
	logic [KC_W-1:0] kk_q;
	logic [KC_W-1:0] ks_q;
	logic [PC_W-1:0] cand_q;
	logic [DIM_W-1:0] comp_q;
	logic            pass_q;
	logic [KC_W-1:0] rank_q;
	logic [1:0]      err_q;

	// Effective register values, taken when a query starts.
	logic [31:0] tk_w, rk_w, others_w, kmax_w;
	always_comb begin
		tk_w = (truth_k_q == 6'd0) ? 32'd1 :
			(32'(truth_k_q) > K_MAX) ? 32'(K_MAX) : 32'(truth_k_q);
		rk_w = (recall_k_q == 6'd0) ? 32'd1 :
			(32'(recall_k_q) > K_MAX) ? 32'(K_MAX) : 32'(recall_k_q);
		kmax_w   = (tk_w > rk_w) ? tk_w : rk_w;
		others_w = 32'(npool_q) - 32'd1;
	end

	// Vector store with two registered read ports.
	logic signed [15:0] mem [DEPTH];
	logic signed [15:0] rd_a_s1, rd_b_s1;
	logic [AW-1:0]      wr_addr_w, addr_a_w, addr_b_w;
	logic               load_w;

	assign wr_addr_w = AW'(AW'(cmd.vector_index) * AW'(DIM_MAX) + AW'(cmd.component_index));
	assign addr_a_w  = AW'(AW'(qi_q) * AW'(DIM_MAX) + AW'(comp_q));
	assign addr_b_w  = AW'(AW'(cand_q) * AW'(DIM_MAX) + AW'(comp_q));
	assign load_w    = cmd_pop && (cmd.kind == CMD_LOAD);

	always_ff @(posedge clk) begin
		if (load_w) begin
			mem[wr_addr_w] <= cmd.component_value;
		end
		rd_a_s1 <= mem[addr_a_w];
		rd_b_s1 <= mem[addr_b_w];
	end

	// Square of the component difference, then saturating accumulation.
	logic signed [16:0] diff_w;
	logic signed [33:0] prod_w;
	logic [33:0]        sq_s2;
	logic               v_s1, last_s1, v_s2, last_s2;
	logic [38:0]        acc_q;
	logic               done_q;
	logic [39:0]        sum_w;

	assign diff_w = {rd_a_s1[15], rd_a_s1} - {rd_b_s1[15], rd_b_s1};
	assign prod_w = diff_w * diff_w;
	assign sum_w  = {1'b0, acc_q} + 40'(sq_s2);

	always_ff @(posedge clk) begin
		sq_s2 <= prod_w;
	end

	// Sorted best list; insertion is evaluated per entry in parallel.
	logic [IX_W-1:0] best_id_q   [K_MAX];
	logic [38:0]     best_dist_q [K_MAX];
	logic [KC_W-1:0] best_count_q;
	logic [K_MAX-1:0] le_w;
	logic [KI_W-1:0] rd_idx_w;
	logic [IX_W-1:0] rd_id_w;
	logic [38:0]     rd_dist_w;
	logic [38:0]     r_band_q, r_wide_q;
	logic [9:0]      band_q, wide_q;

	always_comb begin
		for (int j = 0; j < K_MAX; j++) begin
			le_w[j] = (32'(j) < 32'(best_count_q)) && (best_dist_q[j] <= acc_q);
		end
	end

	always_comb begin
		case (state_q)
			ST_LATCH_W: rd_idx_w = KI_W'(ks_q - KC_W'(1));
			ST_LATCH_B: rd_idx_w = KI_W'(kk_q - KC_W'(1));
			default:    rd_idx_w = KI_W'(rank_q);
		endcase
		rd_id_w   = best_id_q[rd_idx_w];
		rd_dist_w = best_dist_q[rd_idx_w];
	end

	logic slot_free_w;
	logic rsp_valid_q;
	rsp_t rsp_q;
	assign slot_free_w = !rsp_valid_q || rsp_ready;
	assign rsp_valid   = rsp_valid_q;
	assign rsp         = rsp_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.kind == CMD_QUERY) state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (32'(qi_q) >= 32'(npool_q) || npool_q == PC_W'(1)) begin
					state_d = ST_EMIT_ERR;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				if (cand_q == npool_q) begin
					state_d = pass_q ? ST_EMIT : ST_LATCH_W;
				end else if (32'(cand_q) != 32'(qi_q)) begin
					state_d = (dim_q == DIM_W'(0)) ? ST_UPDATE : ST_RUN;
				end
			end
			ST_RUN: begin
				if (comp_q == dim_q - DIM_W'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (done_q) state_d = ST_UPDATE;
			end
			ST_UPDATE:  state_d = ST_NEXT;
			ST_LATCH_W: state_d = ST_LATCH_B;
			ST_LATCH_B: state_d = ST_NEXT;
			ST_EMIT: begin
				if (slot_free_w && rank_q == kk_q - KC_W'(1)) state_d = ST_IDLE;
			end
			ST_EMIT_ERR: begin
				if (slot_free_w) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			v_s1         <= 1'b0;
			last_s1      <= 1'b0;
			v_s2         <= 1'b0;
			last_s2      <= 1'b0;
			done_q       <= 1'b0;
			best_count_q <= '0;
			band_q       <= '0;
			wide_q       <= '0;
			rsp_valid_q  <= 1'b0;
			pass_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == ST_RUN);
			last_s1 <= (state_q == ST_RUN) && (comp_q == dim_q - DIM_W'(1));
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (v_s2 && last_s2) done_q <= 1'b1;
			if ((state_q inside {ST_EMIT, ST_EMIT_ERR}) && slot_free_w) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_SETUP: begin
					best_count_q <= '0;
					band_q       <= '0;
					wide_q       <= '0;
					pass_q       <= 1'b0;
				end
				ST_NEXT: begin
					done_q <= 1'b0;
				end
				ST_UPDATE: begin
					if (!pass_q) begin
						if (!le_w[KI_W'(ks_q - KC_W'(1))] && best_count_q < ks_q) begin
							best_count_q <= best_count_q + KC_W'(1);
						end
					end else if (acc_q <= r_wide_q) begin
						if (wide_q != COUNT_SAT) wide_q <= wide_q + 10'd1;
						if (acc_q <= r_band_q && band_q != COUNT_SAT) band_q <= band_q + 10'd1;
					end
				end
				ST_LATCH_B: pass_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= (sum_w > 40'(DIST_SAT)) ? DIST_SAT : sum_w[38:0];
		end
		case (state_q)
			ST_IDLE: begin
				qi_q    <= cmd.query_index;
				npool_q <= (32'(pool_count_q) > POOL_MAX) ? PC_W'(POOL_MAX) :
					PC_W'(pool_count_q);
				dim_q   <= (32'(dim_in_use_q) > DIM_MAX) ? DIM_W'(DIM_MAX) :
					DIM_W'(dim_in_use_q);
			end
			ST_SETUP: begin
				err_q  <= (32'(qi_q) >= 32'(npool_q)) ? STATUS_BAD_QUERY : STATUS_NO_NBR;
				kk_q   <= (tk_w > others_w) ? KC_W'(others_w) : KC_W'(tk_w);
				ks_q   <= (kmax_w > others_w) ? KC_W'(others_w) : KC_W'(kmax_w);
				cand_q <= '0;
				rank_q <= '0;
			end
			ST_NEXT: begin
				comp_q <= '0;
				acc_q  <= '0;
				if (cand_q != npool_q && 32'(cand_q) == 32'(qi_q)) begin
					cand_q <= cand_q + PC_W'(1);
				end
			end
			ST_RUN: comp_q <= comp_q + DIM_W'(1);
			ST_UPDATE: begin
				cand_q <= cand_q + PC_W'(1);
				if (!pass_q && !le_w[KI_W'(ks_q - KC_W'(1))]) begin
					for (int j = 0; j < K_MAX; j++) begin
						if (!le_w[j]) begin
							if (j == 0 || le_w[(j == 0) ? 0 : j - 1]) begin
								best_id_q[j]   <= IX_W'(cand_q);
								best_dist_q[j] <= acc_q;
							end else begin
								best_id_q[j]   <= best_id_q[(j == 0) ? 0 : j - 1];
								best_dist_q[j] <= best_dist_q[(j == 0) ? 0 : j - 1];
							end
						end
					end
				end
			end
			ST_LATCH_W: r_wide_q <= rd_dist_w;
			ST_LATCH_B: begin
				r_band_q <= rd_dist_w;
				cand_q   <= '0;
			end
			ST_EMIT: begin
				if (slot_free_w) begin
					rsp_q.neighbor_rank <= 5'(rank_q);
					rsp_q.neighbor_id   <= 10'(rd_id_w);
					rsp_q.distance      <= rd_dist_w;
					rsp_q.status        <= STATUS_OK;
					if (rank_q == kk_q - KC_W'(1)) begin
						rsp_q.band_count      <= band_q;
						rsp_q.band_wide_count <= wide_q;
						rsp_q.last            <= 1'b1;
					end else begin
						rsp_q.band_count      <= '0;
						rsp_q.band_wide_count <= '0;
						rsp_q.last            <= 1'b0;
					end
					rank_q <= rank_q + KC_W'(1);
				end
			end
			ST_EMIT_ERR: begin
				if (slot_free_w) begin
					rsp_q <= '{neighbor_rank: '0, neighbor_id: '0, distance: '0,
						band_count: '0, band_wide_count: '0, status: err_q, last: 1'b1};
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/exact_knn_topk_with_tie_bands_top.sv =====
// Top level of the exact k-nearest-neighbor block with tie band counts.
//
// Requests arrive on req_valid/req_ready as req beats. A load beat writes one
// component into the vector store and gives no result; loads stream at one
// beat per cycle through a two-entry command queue while the engine is idle.
// A query beat names a pool vector and returns truth_k result beats (at most
// one per other pool vector) on rsp_valid/rsp_ready, nearest first, the last
// one flagged and carrying the band counts. A bad query index or a pool of
// one gives one status beat.
// A query walks the pool twice; its distances come from the single distance
// pipeline, which reads two store ports. The queue keeps taking beats until
// full while a query runs. When the receiver stalls, the result register
// holds its beat and the engine waits.
// Reset clears control state and loads the register defaults; the store
// contents are undefined until written.
// Configuration is written through cfg_we/cfg_index/cfg_data. The user must
// write it only while idle; the block itself does not enforce this.
`default_nettype none
module exact_knn_topk_with_tie_bands_top #(
	parameter int POOL_MAX = 1024,
	parameter int DIM_MAX  = 128,
	parameter int K_MAX    = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_ready,
	input  knntb_pkg::req_t   req,
	output logic              rsp_valid,
	input  wire               rsp_ready,
	output knntb_pkg::rsp_t   rsp,
	input  wire               cfg_we,
	input  wire [7:0]         cfg_index,
	input  wire [10:0]        cfg_data
);
	import knntb_pkg::*;

	cmd_t cmd;
	logic cmd_valid;
	logic cmd_pop;

	knntb_front #(
		.POOL_MAX(POOL_MAX),
		.DIM_MAX (DIM_MAX)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd)
	);

	knntb_back #(
		.POOL_MAX(POOL_MAX),
		.DIM_MAX (DIM_MAX),
		.K_MAX   (K_MAX)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

// ===== verif/knn_checker.sv =====
// Checker for the k-nearest-neighbor block: mirrors the store, predicts result beats, compares.
`timescale 1ns / 1ps
module knn_checker (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	input  wire              req_ready,
	input  knntb_pkg::req_t  req,
	input  wire              rsp_valid,
	input  wire              rsp_ready,
	input  knntb_pkg::rsp_t  rsp,
	input  wire              cfg_we,
	input  wire [7:0]        cfg_index,
	input  wire [10:0]       cfg_data,
	output int               fail_count,
	output int               outstanding
);
	import knntb_pkg::*;

	localparam int POOL_LIMIT = 1024;
	localparam int DIM_LIMIT  = 128;
	localparam int K_LIMIT    = 32;

	logic signed [15:0] comp_mem [0:POOL_LIMIT*DIM_LIMIT-1];
	logic [10:0] pool_reg;
	logic [7:0]  dim_reg;
	logic [5:0]  topk_reg;
	logic [5:0]  widek_reg;
	rsp_t        neighbor_q[$];

	assign outstanding = neighbor_q.size();

	function automatic int clamp_rank(logic [5:0] v);
		if (v < 1) return 1;
		if (v > K_LIMIT) return K_LIMIT;
		return int'(v);
	endfunction

	function automatic logic [38:0] sq_distance(int a, int b, int dim);
		logic [63:0] acc;
		int diff;
		acc = '0;
		for (int d = 0; d < dim; d++) begin
			diff = int'(comp_mem[a*DIM_LIMIT+d]) - int'(comp_mem[b*DIM_LIMIT+d]);
			acc += 64'(longint'(diff) * longint'(diff));
			if (acc > 64'(DIST_SAT)) acc = 64'(DIST_SAT);
		end
		return acc[38:0];
	endfunction

	// Appends the beats one query should produce, nearest first.
	function automatic void predict_neighbors(int qi);
		int n, dim, others, ksort, kk, cnt, pos, bc, bw;
		int ids [K_LIMIT];
		logic [38:0] dists [K_LIMIT];
		logic [38:0] all_d [POOL_LIMIT];
		logic [38:0] r_band, r_wide;
		rsp_t e;
		n = (pool_reg > POOL_LIMIT) ? POOL_LIMIT : int'(pool_reg);
		dim = (dim_reg > DIM_LIMIT) ? DIM_LIMIT : int'(dim_reg);
		e = '0;
		e.last = 1'b1;
		if (qi >= n) begin
			e.status = STATUS_BAD_QUERY;
			neighbor_q = {neighbor_q, e};
			return;
		end
		others = n - 1;
		if (others == 0) begin
			e.status = STATUS_NO_NBR;
			neighbor_q = {neighbor_q, e};
			return;
		end
		ksort = clamp_rank(topk_reg) > clamp_rank(widek_reg) ?
			clamp_rank(topk_reg) : clamp_rank(widek_reg);
		if (ksort > others) ksort = others;
		kk = clamp_rank(topk_reg) > others ? others : clamp_rank(topk_reg);
		cnt = 0;
		for (int i = 0; i < n; i++) begin
			if (i == qi) continue;
			all_d[i] = sq_distance(qi, i, dim);
			// Equal distances stay behind earlier entries, so ties go to the lower index.
			pos = cnt;
			while (pos > 0 && dists[pos-1] > all_d[i]) pos--;
			if (pos >= ksort) continue;
			for (int j = (cnt < ksort ? cnt : ksort - 1); j > pos; j--) begin
				ids[j] = ids[j-1];
				dists[j] = dists[j-1];
			end
			ids[pos] = i;
			dists[pos] = all_d[i];
			if (cnt < ksort) cnt++;
		end
		r_band = dists[kk-1];
		r_wide = dists[ksort-1];
		bc = 0;
		bw = 0;
		for (int i = 0; i < n; i++) begin
			if (i == qi) continue;
			if (all_d[i] <= r_wide) begin
				if (bw < COUNT_SAT) bw++;
				if (all_d[i] <= r_band && bc < COUNT_SAT) bc++;
			end
		end
		for (int i = 0; i < kk; i++) begin
			e = '0;
			e.neighbor_rank = 5'(i);
			e.neighbor_id = 10'(ids[i]);
			e.distance = dists[i];
			e.status = STATUS_OK;
			if (i == kk - 1) begin
				e.band_count = 10'(bc);
				e.band_wide_count = 10'(bw);
				e.last = 1'b1;
			end
			neighbor_q = {neighbor_q, e};
		end
	endfunction

	task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			pool_reg <= 11'd0;
			dim_reg <= 8'd128;
			topk_reg <= 6'd10;
			widek_reg <= 6'd30;
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POOL_COUNT: pool_reg <= cfg_data;
					REG_DIM_IN_USE: dim_reg <= cfg_data[7:0];
					REG_TRUTH_K: topk_reg <= cfg_data[5:0];
					REG_RECALL_K: widek_reg <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				if (req.req_type == REQ_LOAD)
					comp_mem[int'(req.vector_index)*DIM_LIMIT + int'(req.component_index)] =
						req.component_value;
				else
					predict_neighbors(int'(req.query_index));
			end
			if (rsp_valid && rsp_ready) begin
				if (neighbor_q.size() == 0) begin
					$error("result beat with nothing expected: id %0d status %0d",
						rsp.neighbor_id, rsp.status);
					fail_count++;
				end else begin
					e = neighbor_q.pop_front();
					compare_field("neighbor_rank", 64'(e.neighbor_rank), 64'(rsp.neighbor_rank));
					compare_field("neighbor_id", 64'(e.neighbor_id), 64'(rsp.neighbor_id));
					compare_field("distance", 64'(e.distance), 64'(rsp.distance));
					compare_field("band_count", 64'(e.band_count), 64'(rsp.band_count));
					compare_field("band_wide_count", 64'(e.band_wide_count),
						64'(rsp.band_wide_count));
					compare_field("status", 64'(e.status), 64'(rsp.status));
					compare_field("last", 64'(e.last), 64'(rsp.last));
				end
			end
		end
	end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the k-nearest-neighbor block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
	import knntb_pkg::*;

	localparam logic [7:0] REG_UNUSED = 8'd4;
	localparam int TARGET_BEATS = 450;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        cfg_we;
	logic [7:0]  cfg_index;
	logic [10:0] cfg_data;
	int          fail_count;
	int          outstanding;
	int          sent;
	int          tx_idle;
	int          rx_idle;

	exact_knn_topk_with_tie_bands_top uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	knn_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(negedge clk) rsp_ready <= ($urandom_range(99) >= rx_idle);

	initial begin
		#4ms;
		$display("tb failed");
		$finish;
	end

	function automatic req_t load_beat(int vi, int ci, logic [15:0] val);
		req_t r;
		r = req_t'(44'({$urandom, $urandom}));
		r.req_type = REQ_LOAD;
		r.vector_index = 10'(vi);
		r.component_index = 7'(ci);
		r.component_value = val;
		return r;
	endfunction

	function automatic req_t query_beat(int qi);
		req_t r;
		r = req_t'(44'({$urandom, $urandom}));
		r.req_type = REQ_QUERY;
		r.query_index = 10'(qi);
		return r;
	endfunction

	// Values often come from a tiny range so that equal distances show up.
	function automatic logic [15:0] pick_value();
		return ($urandom_range(1) == 1) ? 16'($urandom) : 16'($urandom_range(3));
	endfunction

	task automatic send(req_t r);
		if (sent < 150) begin
			tx_idle = 27;
			rx_idle = 57;
		end else if (sent < 300) begin
			tx_idle = 57;
			rx_idle = 27;
		end else begin
			tx_idle = 0;
			rx_idle = 0;
		end
		if ($urandom_range(99) < tx_idle) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		sent++;
	endtask

	// Holds off until every result is back and the engine has drained.
	task automatic wait_quiet();
		req_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic set_config(int pool, int dim, int tk, int rk);
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= REG_POOL_COUNT;
		cfg_data <= 11'(pool);
		@(negedge clk);
		cfg_index <= REG_DIM_IN_USE;
		cfg_data <= 11'(dim);
		@(negedge clk);
		cfg_index <= REG_TRUTH_K;
		cfg_data <= 11'(tk);
		@(negedge clk);
		cfg_index <= REG_RECALL_K;
		cfg_data <= 11'(rk);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(int pool, int dim, int tk, int rk, bit reload, int beats);
		int n, d, pick;
		set_config(pool, dim, tk, rk);
		n = pool > 1024 ? 1024 : pool;
		d = dim > 128 ? 128 : dim;
		if (reload)
			for (int v = 0; v < n; v++)
				for (int c = 0; c < d; c++) send(load_beat(v, c, pick_value()));
		for (int i = 0; i < beats; i++) begin
			pick = $urandom_range(99);
			if (pick < 60)
				send(query_beat($urandom_range(99) < 85 ? $urandom_range(n - 1) :
					$urandom_range(1023)));
			else if (pick < 85)
				send(load_beat($urandom_range(n - 1), $urandom_range(127), pick_value()));
			else
				send(load_beat($urandom_range(1023), $urandom_range(127), 16'($urandom)));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sent = 0;
		tx_idle = 27;
		rx_idle = 57;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty pool after reset: every query index is out of the pool.
		send(query_beat(0));
		send(query_beat(1023));

		// One vector: no neighbors; also the zero and top raw ranks.
		set_config(1, 2, 0, 63);
		send(load_beat(0, 0, 16'h8000));
		send(load_beat(0, 1, 16'h7FFF));
		send(query_beat(0));
		send(query_beat(1));

		// Opposite extremes give the largest distance; ranks clamp to the pool.
		set_config(5, 3, 63, 0);
		for (int c = 0; c < 3; c++) send(load_beat(0, c, 16'h8000));
		for (int c = 0; c < 3; c++) send(load_beat(1, c, 16'h7FFF));
		for (int v = 2; v < 5; v++)
			for (int c = 0; c < 3; c++) send(load_beat(v, c, pick_value()));
		send(query_beat(0));
		send(query_beat(1));
		send(query_beat(4));
		send(query_beat(5));

		// A write to a register that does not exist must change nothing.
		wait_quiet();
		cfg_we <= 1'b1;
		cfg_index <= REG_UNUSED;
		cfg_data <= 11'h7FF;
		@(negedge clk);
		cfg_we <= 1'b0;

		// Full dimension, then zero dimension over the saturated pool, then
		// a dimension above the limit on the data already loaded.
		run_phase(2, 128, $urandom_range(63), $urandom_range(63), 1'b1, 6);
		run_phase(2047, 0, 5, 40, 1'b0, 3);
		run_phase(2, 255, 63, 63, 1'b0, 4);
		while (sent < TARGET_BEATS)
			run_phase($urandom_range(2, 12), $urandom_range(1, 6), $urandom_range(63),
				$urandom_range(63), 1'b1, 20);

		wait_quiet();
		if (fail_count == 0 && outstanding == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ===== exact_knn_topk_with_tie_bands_top.f =====
hw/rtl/knntb_pkg.sv
hw/rtl/knntb_front.sv
hw/rtl/knntb_back.sv
hw/rtl/exact_knn_topk_with_tie_bands_top.sv
verif/knn_checker.sv
verif/tb.sv
